@@ rtl/mmq_pkg.sv @@
// Shared types and constants of the min/max 8-bit quantizer.
package mmq_pkg;

   // Result field widths
   localparam int MIN_W   = 16;
   localparam int SCALE_W = 17;
   localparam int CODE_W  = 8;

   // Divider: quotient register and step counter
   localparam int QUOT_W      = 8;
   localparam int STEP_W      = 4;
   localparam int CODE_STEPS  = 8;

   // Scale = span + floor((span + 127) / 255), saturated to the field maximum.
   // The quotient by 255 is a reciprocal multiply, exact below the saturation span.
   localparam int SCALE_ROUND       = 127;
   localparam int SCALE_RECIP       = 131587;
   localparam int SCALE_RECIP_SHIFT = 25;
   localparam int SCALE_PROD_W      = 35;
   localparam int SCALE_SAT_SPAN    = 130560;
   localparam int SCALE_MAX         = 131071;
   localparam int CODE_MAX          = 255;

   // Result kinds
   localparam logic KIND_HEADER = 1'b0;
   localparam logic KIND_CODE   = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE_START,
      ST_CODE_SETUP,
      ST_DIV,
      ST_DONE
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic take;         // accept the item on the request ports
      logic scale_start;  // register the header scale
      logic code_start;   // classify the sample and load divider for its code
      logic out_write;    // move the finished result into the output register
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic req_quant;    // item on the request ports is a quantize sample
      logic req_closes;   // item on the request ports closes a scan
      logic code_special; // code settled without division
      logic div_busy;
      logic out_full;
   } status_type;

endpackage

@@ rtl/mmq_divider.sv @@
// Restoring divider, one quotient bit per cycle, for the quantized code.
module mmq_divider #(
   parameter int WORK_W = 33
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [WORK_W-1:0]          num,
   input  logic [WORK_W-1:0]          den_top,
   input  logic [mmq_pkg::STEP_W-1:0] steps,
   output logic                       busy,
   output logic [mmq_pkg::QUOT_W-1:0] quot
);
   import mmq_pkg::*;

   logic [WORK_W-1:0] rem_ff, rem_in;
   logic [WORK_W-1:0] dsh_ff, dsh_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;
   logic [STEP_W-1:0] count_ff, count_in;
   logic              busy_ff, busy_in;
   logic              ge;

   // One subtract-and-compare step against the shifted divisor
   always_comb begin
      ge       = (rem_ff >= dsh_ff);
      rem_in   = rem_ff;
      dsh_in   = dsh_ff;
      quot_in  = quot_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      if (start) begin
         rem_in   = num;
         dsh_in   = den_top;
         quot_in  = '0;
         count_in = steps;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (ge) begin
            rem_in = rem_ff - dsh_ff;
         end
         dsh_in   = dsh_ff >> 1;
         quot_in  = {quot_ff[QUOT_W-2:0], ge};
         count_in = count_ff - STEP_W'(1);
         if (count_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quot_ff <= quot_in;
   end

   assign busy = busy_ff;
   assign quot = quot_ff;

endmodule

@@ rtl/mmq_datapath.sv @@
// Datapath: running min/max, layer header registers, divider and output register.
module mmq_datapath #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  mmq_pkg::cmd_type                   cmd,
   output mmq_pkg::status_type                status,
   input  logic                               req_func,
   input  logic signed [SAMPLE_BITS-1:0]      req_value,
   input  logic                               req_last,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_kind,
   output logic signed [mmq_pkg::MIN_W-1:0]   rsp_min_value,
   output logic [mmq_pkg::SCALE_W-1:0]        rsp_scale,
   output logic [mmq_pkg::CODE_W-1:0]         rsp_code
);
   import mmq_pkg::*;

   localparam int WORK_W = SAMPLE_BITS + 17;
   localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   logic signed [SAMPLE_BITS-1:0] run_min_ff, run_max_ff;
   logic signed [SAMPLE_BITS-1:0] layer_min_ff;
   logic [SAMPLE_BITS-1:0]        layer_span_ff;
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic                          func_ff;
   logic                          special_ff;
   logic [CODE_W-1:0]             fix_code_ff;
   logic [SCALE_W-1:0]            scale_ff;

   logic                          rsp_valid_ff;
   logic                          rsp_kind_ff;
   logic signed [MIN_W-1:0]       rsp_min_ff;
   logic [SCALE_W-1:0]            rsp_scale_ff;
   logic [CODE_W-1:0]             rsp_code_ff;

   logic signed [SAMPLE_BITS-1:0] new_min, new_max;
   logic signed [SAMPLE_BITS:0]   diff;
   logic [SAMPLE_BITS-1:0]        ud;
   logic                          code_zero, code_full;
   logic                          div_start;
   logic [WORK_W-1:0]             div_num, div_den;
   logic [STEP_W-1:0]             div_steps;
   logic                          div_busy;
   logic [QUOT_W-1:0]             div_quot;

   logic                          scale_sat;
   logic [SCALE_W-1:0]            scale_num;
   logic [SCALE_PROD_W-1:0]       scale_prod;
   logic [SCALE_PROD_W-SCALE_RECIP_SHIFT-1:0] scale_quo;
   logic [SCALE_W-1:0]            scale_val;

   // Running extremes including the sample on the request ports
   always_comb begin
      new_min = (req_value < run_min_ff) ? req_value : run_min_ff;
      new_max = (req_value > run_max_ff) ? req_value : run_max_ff;
   end

   // Offset of the held sample from the layer minimum and its range class
   always_comb begin
      diff      = {sample_ff[SAMPLE_BITS-1], sample_ff}
                - {layer_min_ff[SAMPLE_BITS-1], layer_min_ff};
      ud        = diff[SAMPLE_BITS-1:0];
      code_zero = (layer_span_ff == '0) || diff[SAMPLE_BITS] || (diff == '0);
      code_full = !code_zero && (ud >= layer_span_ff);
   end

   // Header scale: span + floor((span + 127) / 255), quotient by reciprocal multiply
   always_comb begin
      scale_sat  = (WORK_W'(layer_span_ff) >= WORK_W'(SCALE_SAT_SPAN));
      scale_num  = SCALE_W'(layer_span_ff) + SCALE_W'(SCALE_ROUND);
      scale_prod = SCALE_PROD_W'(scale_num) * SCALE_PROD_W'(SCALE_RECIP);
      scale_quo  = scale_prod[SCALE_PROD_W-1:SCALE_RECIP_SHIFT];
      scale_val  = SCALE_W'(layer_span_ff) + SCALE_W'(scale_quo);
   end

   // Divider operands for the rounded code
   always_comb begin
      div_start = cmd.code_start;
      // (ud*510 + span) / (2*span), top divisor step is 2*span << 7
      div_num   = (WORK_W'(ud) << 9) - (WORK_W'(ud) << 1) + WORK_W'(layer_span_ff);
      div_den   = WORK_W'(layer_span_ff) << CODE_STEPS;
      div_steps = STEP_W'(CODE_STEPS);
   end

   mmq_divider #(
      .WORK_W(WORK_W)
   ) u_divider (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .num     (div_num),
      .den_top (div_den),
      .steps   (div_steps),
      .busy    (div_busy),
      .quot    (div_quot)
   );

   // Scan state and layer header
   always_ff @(posedge clock) begin
      if (reset) begin
         run_min_ff    <= S_MAX;
         run_max_ff    <= S_MIN;
         layer_min_ff  <= '0;
         layer_span_ff <= '0;
      end else if (cmd.take && !req_func) begin
         if (req_last) begin
            layer_min_ff  <= new_min;
            layer_span_ff <= SAMPLE_BITS'(new_max - new_min);
            run_min_ff    <= S_MAX;
            run_max_ff    <= S_MIN;
         end else begin
            run_min_ff <= new_min;
            run_max_ff <= new_max;
         end
      end
   end

   // Held item and settled results
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         func_ff   <= req_func;
         sample_ff <= req_value;
      end
      if (cmd.code_start) begin
         special_ff  <= code_zero || code_full;
         fix_code_ff <= code_full ? CODE_W'(CODE_MAX) : '0;
      end
      if (cmd.scale_start) begin
         scale_ff <= scale_sat ? SCALE_W'(SCALE_MAX) : scale_val;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_write) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.out_write) begin
         if (func_ff == KIND_CODE) begin
            rsp_kind_ff  <= KIND_CODE;
            rsp_min_ff   <= '0;
            rsp_scale_ff <= '0;
            rsp_code_ff  <= special_ff ? fix_code_ff : div_quot[CODE_W-1:0];
         end else begin
            rsp_kind_ff  <= KIND_HEADER;
            rsp_min_ff   <= MIN_W'(layer_min_ff);
            rsp_scale_ff <= scale_ff;
            rsp_code_ff  <= '0;
         end
      end
   end

   always_comb begin
      status.req_quant    = req_func;
      status.req_closes   = !req_func && req_last;
      status.code_special = code_zero || code_full;
      status.div_busy     = div_busy;
      status.out_full     = rsp_valid_ff;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_min_value = rsp_min_ff;
   assign rsp_scale     = rsp_scale_ff;
   assign rsp_code      = rsp_code_ff;

endmodule

@@ rtl/mmq_ctrl.sv @@
// Controller state machine: item intake, divider sequencing and result hand-off.
module mmq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                rsp_ready,
   input  mmq_pkg::status_type status,
   output mmq_pkg::cmd_type    cmd
);
   import mmq_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               if (status.req_quant) begin
                  state_in = ST_CODE_SETUP;
               end else if (status.req_closes) begin
                  state_in = ST_SCALE_START;
               end
            end
         end
         ST_SCALE_START: begin
            cmd.scale_start = 1'b1;
            state_in        = ST_DONE;
         end
         ST_CODE_SETUP: begin
            cmd.code_start = 1'b1;
            state_in       = status.code_special ? ST_DONE : ST_DIV;
         end
         ST_DIV: begin
            if (!status.div_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!status.out_full || rsp_ready) begin
               cmd.out_write = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/minmax_uint8_quantizer_core.sv @@
// Top level of the min/max 8-bit quantizer: controller plus datapath.
// A scan item without last gives no result.
// A scan item with last gives its header result (scale by reciprocal multiply).
// A quantize item gives its code without division at or beyond the range limits, else through the divider.
// One item at a time; the 8-step restoring divider for the code is the long path.
// Synchronous reset clears the scan extremes, the layer header and all handshake state.
module minmax_uint8_quantizer_core #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_func,
   input  logic signed [SAMPLE_BITS-1:0]      req_value,
   input  logic                               req_last,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_kind,
   output logic signed [mmq_pkg::MIN_W-1:0]   rsp_min_value,
   output logic [mmq_pkg::SCALE_W-1:0]        rsp_scale,
   output logic [mmq_pkg::CODE_W-1:0]         rsp_code
);
   import mmq_pkg::*;

   cmd_type    cmd;
   status_type status;

   mmq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mmq_datapath #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_func      (req_func),
      .req_value     (req_value),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_kind      (rsp_kind),
      .rsp_min_value (rsp_min_value),
      .rsp_scale     (rsp_scale),
      .rsp_code      (rsp_code)
   );

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the min/max 8-bit quantizer core.
module testbench;
   import mmq_pkg::*;

   // Request func codes
   localparam logic FUNC_SCAN  = 1'b0;
   localparam logic FUNC_QUANT = 1'b1;

   localparam int SAMPLE_W    = 16;
   localparam int SAMPLE_MIN  = -32768;
   localparam int SAMPLE_MAX  = 32767;
   localparam int MAX_GAP     = 40;
   localparam int DRAIN_WAIT  = 40;
   localparam int PHASE_ITEMS = 300;

   typedef struct {
      logic                       kind;
      logic signed [MIN_W-1:0]    min_value;
      logic [SCALE_W-1:0]         scale;
      logic [CODE_W-1:0]          code;
   } quant_result_type;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic                       req_func;
   logic signed [SAMPLE_W-1:0] req_value;
   logic                       req_last;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic                       rsp_kind;
   logic signed [MIN_W-1:0]    rsp_min_value;
   logic [SCALE_W-1:0]         rsp_scale;
   logic [CODE_W-1:0]          rsp_code;

   // Predictor state: scan extremes and the current layer header
   logic signed [SAMPLE_W-1:0] scan_min;
   logic signed [SAMPLE_W-1:0] scan_max;
   logic signed [SAMPLE_W-1:0] header_min;
   logic [SCALE_W-1:0]         header_span;

   quant_result_type predicted_outputs[$];
   quant_result_type oldest;

   int send_idle_pct;
   int rsp_stall_pct;
   int holdoff_cycles;
   int items_sent;
   int error_count;

   minmax_uint8_quantizer_core #(
      .SAMPLE_BITS(SAMPLE_W)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_func(req_func),
      .req_value(req_value),
      .req_last(req_last),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_kind(rsp_kind),
      .rsp_min_value(rsp_min_value),
      .rsp_scale(rsp_scale),
      .rsp_code(rsp_code)
   );

   // Clock, period 10
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard stop for a hung run
   initial begin
      #8000000;
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic clear_scan();
      scan_min = SAMPLE_W'(SAMPLE_MAX);
      scan_max = SAMPLE_W'(SAMPLE_MIN);
   endtask

   // Work out the result an accepted item causes, if any
   task automatic quantize_predict(input logic func, input logic signed [SAMPLE_W-1:0] value,
                                   input logic last);
      quant_result_type r;
      int span;
      int diff;
      int scale;
      r.kind = KIND_CODE;
      r.min_value = '0;
      r.scale = '0;
      r.code = '0;
      if (func == FUNC_SCAN) begin
         if (value < scan_min) scan_min = value;
         if (value > scan_max) scan_max = value;
         if (last) begin
            span = int'(scan_max) - int'(scan_min);
            header_min = scan_min;
            header_span = span[SCALE_W-1:0];
            scale = (span * 512 + 255) / 510;
            if (scale > SCALE_MAX) scale = SCALE_MAX;
            r.kind = KIND_HEADER;
            r.min_value = scan_min;
            r.scale = scale[SCALE_W-1:0];
            predicted_outputs.push_back(r);
            clear_scan();
         end
      end else begin
         span = int'(header_span);
         diff = int'(value) - int'(header_min);
         if (span == 0 || diff <= 0) r.code = '0;
         else if (diff >= span) r.code = CODE_W'(CODE_MAX);
         else r.code = CODE_W'((diff * 510 + span) / (span * 2));
         predicted_outputs.push_back(r);
      end
   endtask

   // Offer one item, with an optional idle gap first, and wait until it is taken
   task automatic send_item(input logic func, input logic signed [SAMPLE_W-1:0] value,
                            input logic last);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct) gap++;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_func  <= func;
      req_value <= value;
      req_last  <= last;
      do @(posedge clock); while (!req_ready);
      quantize_predict(func, value, last);
      items_sent++;
   endtask

   function automatic int pick_in(input int lo, input int hi);
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   // Receiver: random stalls plus an optional long hold-off
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holdoff_cycles > 0) begin
            rsp_ready <= 1'b0;
            holdoff_cycles--;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
         end
      end
   end

   // Result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (predicted_outputs.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind=%0b code=%0d", rsp_kind,
                                      rsp_code));
         end else begin
            oldest = predicted_outputs.pop_front();
            if (rsp_kind !== oldest.kind)
               report_mismatch($sformatf("kind %0b, want %0b", rsp_kind, oldest.kind));
            if (rsp_min_value !== oldest.min_value)
               report_mismatch($sformatf("min_value %0d, want %0d", rsp_min_value,
                                         oldest.min_value));
            if (rsp_scale !== oldest.scale)
               report_mismatch($sformatf("scale %0d, want %0d", rsp_scale, oldest.scale));
            if (rsp_code !== oldest.code)
               report_mismatch($sformatf("code %0d, want %0d", rsp_code, oldest.code));
         end
      end
   end

   // Random layers: scan pass then quantize pass, mixed with loose items
   task automatic run_layers(input int budget);
      int first;
      int lo;
      int hi;
      int pad;
      int n_scan;
      int n_quant;
      int k;
      first = items_sent;
      while (items_sent - first < budget) begin
         if ($urandom_range(0, 99) < 12) begin
            send_item(1'($urandom), 16'($urandom), 1'($urandom));
         end else begin
            lo = pick_in(SAMPLE_MIN, SAMPLE_MAX);
            case ($urandom_range(0, 9))
               0:       hi = lo;
               1, 2:    hi = lo + int'($urandom_range(0, 15));
               3, 4, 5, 6: hi = lo + int'($urandom_range(0, 2047));
               default: hi = pick_in(SAMPLE_MIN, SAMPLE_MAX);
            endcase
            if (hi > SAMPLE_MAX) hi = SAMPLE_MAX;
            if (hi < lo) begin
               k = lo;
               lo = hi;
               hi = k;
            end
            // scan pass, now and then a quantize item slipped in
            n_scan = $urandom_range(1, 8);
            for (k = 0; k < n_scan; k++) begin
               if ($urandom_range(0, 19) == 0)
                  send_item(FUNC_QUANT, 16'(pick_in(SAMPLE_MIN, SAMPLE_MAX)), 1'b0);
               send_item(FUNC_SCAN, 16'(pick_in(lo, hi)), k == n_scan - 1);
            end
            // quantize pass, reaching a little beyond the layer range
            pad = (hi - lo) / 8 + 2;
            lo = (lo - pad < SAMPLE_MIN) ? SAMPLE_MIN : lo - pad;
            hi = (hi + pad > SAMPLE_MAX) ? SAMPLE_MAX : hi + pad;
            n_quant = $urandom_range(1, 12);
            for (k = 0; k < n_quant; k++)
               send_item(FUNC_QUANT, 16'(pick_in(lo, hi)), $urandom_range(0, 9) == 0);
         end
      end
   endtask

   task automatic set_idling(input int send_pct, input int stall_pct);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
   endtask

   // Extremes and the named corner cases
   task automatic test_directed();
      set_idling(0, 0);
      // quantize before any header: codes are 0, last is ignored
      send_item(FUNC_QUANT, 16'(-32768), 1'b0);
      send_item(FUNC_QUANT, 16'(32767), 1'b1);
      // single-item layer: zero span
      send_item(FUNC_SCAN, 16'(1234), 1'b1);
      send_item(FUNC_QUANT, 16'(1234), 1'b0);
      send_item(FUNC_QUANT, 16'(32767), 1'b0);
      // full-range layer
      send_item(FUNC_SCAN, 16'(-32768), 1'b0);
      send_item(FUNC_SCAN, 16'(32767), 1'b1);
      send_item(FUNC_QUANT, 16'(-32768), 1'b0);
      send_item(FUNC_QUANT, 16'(32767), 1'b0);
      send_item(FUNC_QUANT, 16'(0), 1'b0);
      send_item(FUNC_QUANT, 16'(-1), 1'b0);
      send_item(FUNC_QUANT, 16'sh5555, 1'b0);
      // quantize item in the middle of a scan uses the old header
      send_item(FUNC_SCAN, 16'(300), 1'b0);
      send_item(FUNC_SCAN, 16'(100), 1'b0);
      send_item(FUNC_QUANT, 16'(32767), 1'b0);
      send_item(FUNC_SCAN, 16'(200), 1'b1);
      // below min, above max, edges, rounding
      send_item(FUNC_QUANT, 16'(50), 1'b0);
      send_item(FUNC_QUANT, 16'(400), 1'b0);
      send_item(FUNC_QUANT, 16'(100), 1'b0);
      send_item(FUNC_QUANT, 16'(301), 1'b0);
      send_item(FUNC_QUANT, 16'(150), 1'b1);
      send_item(FUNC_QUANT, 16'(299), 1'b0);
      // zero span on a negative sample
      send_item(FUNC_SCAN, 16'(-5), 1'b1);
      send_item(FUNC_QUANT, 16'(-5), 1'b0);
   endtask

   task automatic test_layers_streaming();
      set_idling(0, 0);
      run_layers(PHASE_ITEMS);
   endtask

   task automatic test_layers_sender_idle();
      set_idling(82, 0);
      run_layers(PHASE_ITEMS);
   endtask

   task automatic test_layers_receiver_stall();
      set_idling(0, 82);
      run_layers(PHASE_ITEMS);
   endtask

   task automatic test_layers_both_idle();
      set_idling(18, 18);
      run_layers(PHASE_ITEMS);
   endtask

   // Long receiver hold-off while items keep coming: the input must stall
   task automatic test_input_backpressure();
      int k;
      set_idling(0, 0);
      holdoff_cycles = 400;
      send_item(FUNC_SCAN, 16'(-1000), 1'b0);
      send_item(FUNC_SCAN, 16'(1000), 1'b1);
      for (k = 0; k < 16; k++)
         send_item(FUNC_QUANT, 16'(pick_in(-1200, 1200)), 1'b0);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = FUNC_SCAN;
      req_value = '0;
      req_last = 1'b0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      holdoff_cycles = 0;
      items_sent = 0;
      error_count = 0;
      clear_scan();
      header_min = '0;
      header_span = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_layers_streaming();
      test_layers_sender_idle();
      test_layers_receiver_stall();
      test_input_backpressure();
      test_layers_both_idle();

      @(negedge clock);
      req_valid <= 1'b0;
      while (predicted_outputs.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0 && predicted_outputs.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

@@ minmax_uint8_quantizer_core.f @@
rtl/mmq_pkg.sv
rtl/mmq_divider.sv
rtl/mmq_datapath.sv
rtl/mmq_ctrl.sv
rtl/minmax_uint8_quantizer_core.sv
verif/testbench.sv
